// ===== src/dqms_pkg.sv =====
`default_nettype none

package dqms_pkg;

   // Request kind codes
   localparam logic [2:0] KIND_PUSH_BACK  = 3'd0;
   localparam logic [2:0] KIND_PUSH_FRONT = 3'd1;
   localparam logic [2:0] KIND_POP_BACK   = 3'd2;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd3;
   localparam logic [2:0] KIND_SEARCH     = 3'd4;

   localparam int KIND_W = 3;

endpackage

`default_nettype wire

// ===== src/dqms_ram.sv =====
`default_nettype none

module dqms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/deque_with_membership_search.sv =====
// Bounded double-ended queue of signed words with membership search.
// Request channel (req_valid/req_ready): req_kind selects push back, push
// front, pop back, pop front or search; req_value is the word to push or to
// look for. Every request yields exactly one word on the response channel
// (rsp_valid/rsp_ready): rsp_ok (success or found) and rsp_count, the number
// of stored entries after the request.
// Sequence: push, pop and unknown kinds go from acceptance through the POST
// state to the output register. A search reads the occupied entries one per
// cycle through the single read port of the entry RAM and one comparator,
// ending early on a match; an empty store answers without a scan.
// The block takes one request at a time; req_ready is high only while idle.
// The response sits in an output register: a new request is accepted while
// it waits, and a finished result waits in the block until that register
// frees up, so a stalled receiver holds off further requests.
// Reset empties the store (head and count cleared) and drops any pending
// response; entry contents are not cleared, none is read before written.
`default_nettype none

module deque_with_membership_search #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [dqms_pkg::KIND_W-1:0]   req_kind,
   input  wire logic signed [DATA_WIDTH-1:0]  req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_ok,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_count
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SW    = CNT_W + 1;

   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [AW-1:0]    PTR_LAST = AW'(DEPTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_POST
   } state_type;

   state_type             state_ff, state_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [AW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      left_ff, left_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic                  cmp_last_ff, cmp_last_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic                  pend_ok_ff, pend_ok_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic                  rd_en;
   logic [DATA_WIDTH-1:0] rd_data;

   logic                  req_fire;
   logic                  rsp_free;
   logic                  full;
   logic                  empty;
   logic [SW-1:0]         back_sum;
   logic [AW-1:0]         back_slot;
   logic [AW-1:0]         head_dec;
   logic [AW-1:0]         head_inc;
   logic [AW-1:0]         rd_ptr_inc;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign full      = (count_ff == CNT_FULL);
   assign empty     = (count_ff == '0);

   // ring slot arithmetic, one wrap correction each
   assign back_sum   = SW'(head_ff) + SW'(count_ff);
   assign back_slot  = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH))
                                                : back_sum[AW-1:0];
   assign head_dec   = (head_ff == '0) ? PTR_LAST : head_ff - AW'(1);
   assign head_inc   = (head_ff == PTR_LAST) ? '0 : head_ff + AW'(1);
   assign rd_ptr_inc = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + AW'(1);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      left_in      = left_ff;
      cmp_vld_in   = cmp_vld_ff;
      cmp_last_in  = cmp_last_ff;
      key_in       = key_ff;
      pend_ok_in   = pend_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_count_in = rsp_count_ff;
      wr_en        = 1'b0;
      wr_addr      = back_slot;
      rd_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pend_ok_in = 1'b0;
               state_in   = ST_POST;
               unique case (req_kind)
                  dqms_pkg::KIND_PUSH_BACK: begin
                     if (!full) begin
                        wr_en      = 1'b1;
                        wr_addr    = back_slot;
                        count_in   = count_ff + CNT_W'(1);
                        pend_ok_in = 1'b1;
                     end
                  end
                  dqms_pkg::KIND_PUSH_FRONT: begin
                     if (!full) begin
                        wr_en      = 1'b1;
                        wr_addr    = head_dec;
                        head_in    = head_dec;
                        count_in   = count_ff + CNT_W'(1);
                        pend_ok_in = 1'b1;
                     end
                  end
                  dqms_pkg::KIND_POP_BACK: begin
                     if (!empty) begin
                        count_in   = count_ff - CNT_W'(1);
                        pend_ok_in = 1'b1;
                     end
                  end
                  dqms_pkg::KIND_POP_FRONT: begin
                     if (!empty) begin
                        head_in    = head_inc;
                        count_in   = count_ff - CNT_W'(1);
                        pend_ok_in = 1'b1;
                     end
                  end
                  dqms_pkg::KIND_SEARCH: begin
                     key_in      = req_value;
                     rd_ptr_in   = head_ff;
                     left_in     = count_ff;
                     cmp_vld_in  = 1'b0;
                     cmp_last_in = 1'b0;
                     if (!empty) begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     // unknown kind: no effect, not ok
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // issue one read a cycle from the front towards the back
            if (left_ff != '0) begin
               rd_en       = 1'b1;
               rd_ptr_in   = rd_ptr_inc;
               left_in     = left_ff - CNT_W'(1);
               cmp_vld_in  = 1'b1;
               cmp_last_in = (left_ff == CNT_W'(1));
            end else begin
               cmp_vld_in  = 1'b0;
            end
            // compare the word read last cycle
            if (cmp_vld_ff) begin
               if (rd_data == key_ff) begin
                  pend_ok_in = 1'b1;
                  cmp_vld_in = 1'b0;
                  state_in   = ST_POST;
               end else if (cmp_last_ff) begin
                  pend_ok_in = 1'b0;
                  cmp_vld_in = 1'b0;
                  state_in   = ST_POST;
               end
            end
         end

         ST_POST: begin
            // hand the result to the output register once it is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = pend_ok_ff;
               rsp_count_in = count_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_ptr_ff    <= rd_ptr_in;
      left_ff      <= left_in;
      cmp_last_ff  <= cmp_last_in;
      key_ff       <= key_in;
      pend_ok_ff   <= pend_ok_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_count_ff <= rsp_count_in;
   end

   // entry store
   dqms_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = rsp_ok_ff;
   assign rsp_count = rsp_count_ff;

endmodule

`default_nettype wire

// ===== src/dqms_checker.sv =====
`default_nettype none

module dqms_checker #(
   parameter int DEPTH = 16
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic                         rsp_ok,
   input wire logic [$clog2(DEPTH+1)-1:0]   rsp_count
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_count))
      else $error("response word changed while stalled");

   // count never exceeds the store depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count <= CNT_W'(DEPTH)))
      else $error("response count beyond depth");

   // reset leaves the block idle with no response pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");

   // every accepted request leaves the block busy in the cycle after
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted in back-to-back cycles");

   // a fresh response word only comes out of a busy block
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response raised while the block was idle");

endmodule

bind deque_with_membership_search dqms_checker #(
   .DEPTH (DEPTH)
) u_dqms_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_ok    (rsp_ok),
   .rsp_count (rsp_count)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int KIND_W      = dqms_pkg::KIND_W;
   localparam int COUNT_W     = $clog2(DEPTH + 1);
   localparam int SLOT_W      = $clog2(DEPTH);
   localparam int RESET_CYCLES = 9;
   localparam int MAX_IDLE    = 18;
   localparam int LONG_HOLD   = 150;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1410;
   localparam int MAX_PRINTED = 100;

   // kinds the block must answer with ok low and count unchanged
   localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;

   typedef struct packed {
      logic               ok;
      logic [COUNT_W-1:0] count;
   } deq_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   wire logic                     req_ready;
   logic [KIND_W-1:0]             req_kind = '0;
   logic signed [DATA_WIDTH-1:0]  req_value = '0;
   wire logic                     rsp_valid;
   logic                          rsp_ready = 1'b0;
   wire logic                     rsp_ok;
   wire logic [COUNT_W-1:0]       rsp_count;

   deque_with_membership_search #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .req_value (req_value),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_ok    (rsp_ok),
      .rsp_count (rsp_count)
   );

   always #4 clock = ~clock;

   // shadow copy of the deque
   logic [DATA_WIDTH-1:0] deq_slots [DEPTH];
   logic [SLOT_W-1:0]     deq_head = '0;
   logic [COUNT_W-1:0]    deq_fill = '0;

   deq_result_type pending_results[$];

   bit idle_on = 1'b0;
   int rsp_hold_request = 0;
   int cycle_count = 0;
   int mismatch_count = 0;
   int checked_words = 0;

   // tallies for the closing summary
   int n_requests = 0, n_stored = 0, n_removed = 0, n_searches = 0, n_hits = 0;
   int n_full_refused = 0, n_empty_refused = 0, n_unknown = 0;

   // one request's effect on the shadow deque; queues the expected word
   function automatic void predict_request(input logic [KIND_W-1:0] kind,
                                           input logic [DATA_WIDTH-1:0] value);
      deq_result_type    res;
      logic [SLOT_W-1:0] offs;
      res.ok = 1'b0;
      n_requests++;
      case (kind)
         dqms_pkg::KIND_PUSH_BACK, dqms_pkg::KIND_PUSH_FRONT: begin
            if (deq_fill < DEPTH) begin
               if (kind == dqms_pkg::KIND_PUSH_BACK) begin
                  offs = deq_fill[SLOT_W-1:0];
                  deq_slots[deq_head + offs] = value;
               end else begin
                  deq_head = deq_head - 1'b1;
                  deq_slots[deq_head] = value;
               end
               deq_fill++;
               res.ok = 1'b1;
               n_stored++;
            end else begin
               n_full_refused++;
            end
         end
         dqms_pkg::KIND_POP_BACK, dqms_pkg::KIND_POP_FRONT: begin
            if (deq_fill > 0) begin
               if (kind == dqms_pkg::KIND_POP_FRONT) deq_head = deq_head + 1'b1;
               deq_fill--;
               res.ok = 1'b1;
               n_removed++;
            end else begin
               n_empty_refused++;
            end
         end
         dqms_pkg::KIND_SEARCH: begin
            n_searches++;
            for (int i = 0; i < deq_fill; i++) begin
               offs = i[SLOT_W-1:0];
               if (deq_slots[deq_head + offs] == value) res.ok = 1'b1;
            end
            if (res.ok) n_hits++;
         end
         default: n_unknown++;
      endcase
      res.count = deq_fill;
      pending_results.push_back(res);
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTED) $display("%0t ns: MISMATCH %s", $realtime, msg);
      mismatch_count++;
   endtask

   // offer one word on the request side; expectation is queued on acceptance
   task automatic send_word(input logic [KIND_W-1:0] kind, input logic [DATA_WIDTH-1:0] value);
      int gap;
      gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_request(kind, value);
   endtask

   // response side: random stall per word, or a long hold when a test asks
   initial begin : rsp_side
      int wait_cycles;
      wait (!reset);
      forever begin
         if (rsp_hold_request > 0) begin
            wait_cycles = rsp_hold_request;
            rsp_hold_request = 0;
         end else begin
            wait_cycles = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         end
         @(negedge clock);
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // compare every accepted response word with the oldest expectation
   always @(posedge clock) begin
      deq_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         checked_words++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("response with nothing pending (ok=%0b count=%0d)",
                                      rsp_ok, rsp_count));
         end else begin
            want = pending_results.pop_front();
            if (rsp_ok !== want.ok)
               report_mismatch($sformatf("ok: got %0b, want %0b", rsp_ok, want.ok));
            if (rsp_count !== want.count)
               report_mismatch($sformatf("count: got %0d, want %0d", rsp_count, want.count));
         end
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d words still pending",
               cycle_count, pending_results.size());
      $display("end of test: mismatches");
      $finish;
   end

   // value source: stored words for searches, a pool of corner words, or anything
   function automatic logic [DATA_WIDTH-1:0] pick_value(input logic [KIND_W-1:0] kind);
      logic [SLOT_W-1:0] offs;
      if (kind == dqms_pkg::KIND_SEARCH && deq_fill > 0 && $urandom_range(0, 1) == 1) begin
         offs = SLOT_W'($urandom_range(0, deq_fill - 1));
         return deq_slots[deq_head + offs];
      end
      if ($urandom_range(0, 1) == 1) begin
         case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            default: return 32'h0000_5A5A;
         endcase
      end
      return $urandom;
   endfunction

   // refusals and no-ops on the empty store
   task automatic test_empty_store();
      send_word(dqms_pkg::KIND_SEARCH, 32'h0000_0000);
      send_word(dqms_pkg::KIND_POP_BACK, 32'hFFFF_FFFF);
      send_word(dqms_pkg::KIND_POP_FRONT, 32'h0000_0000);
      for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
         send_word(k[KIND_W-1:0], $urandom);
   endtask

   // fill from both ends with corner words, then push into the full store
   task automatic test_fill_to_full();
      logic [DATA_WIDTH-1:0] word;
      for (int i = 0; i < DEPTH; i++) begin
         case (i % 4)
            0: word = 32'h8000_0000 + i;
            1: word = 32'h7FFF_FFFF - i;
            2: word = i;
            default: word = 32'hFFFF_FFFF - i;
         endcase
         send_word((i % 2 == 0) ? dqms_pkg::KIND_PUSH_BACK : dqms_pkg::KIND_PUSH_FRONT, word);
      end
      send_word(dqms_pkg::KIND_PUSH_BACK, 32'h1234_5678);
      send_word(dqms_pkg::KIND_PUSH_FRONT, 32'h8765_4321);
   endtask

   // searches at the front, the back and for a word that is absent
   task automatic test_search_hits();
      send_word(dqms_pkg::KIND_SEARCH, deq_slots[deq_head]);
      send_word(dqms_pkg::KIND_SEARCH, deq_slots[deq_head - 1'b1]);
      send_word(dqms_pkg::KIND_SEARCH, 32'h1234_5678);
   endtask

   // stall the response side long enough that the block stops taking requests
   task automatic test_backpressure();
      idle_on = 1'b0;
      rsp_hold_request = LONG_HOLD;
      repeat (10) begin
         if ($urandom_range(0, 1) == 1) begin
            send_word(dqms_pkg::KIND_SEARCH, pick_value(dqms_pkg::KIND_SEARCH));
         end else begin
            send_word(KIND_W'($urandom_range(dqms_pkg::KIND_PUSH_BACK,
                                             dqms_pkg::KIND_POP_FRONT)), $urandom);
         end
      end
   endtask

   // random traffic in runs that lean toward filling, draining or neither
   task automatic test_random_traffic(input int n_items);
      int                sent;
      int                lean;
      int                roll;
      bit                is_push;
      bit                at_front;
      logic [KIND_W-1:0] kind;
      sent = 0;
      while (sent < n_items) begin
         lean = $urandom_range(0, 2);
         idle_on = ($urandom_range(0, 3) != 0);
         repeat (40) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               kind = KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
            end else if (roll < 30) begin
               kind = dqms_pkg::KIND_SEARCH;
            end else begin
               is_push  = $urandom_range(0, 99) < (lean == 0 ? 75 : (lean == 1 ? 25 : 50));
               at_front = 1'($urandom_range(0, 1));
               if (is_push) kind = at_front ? dqms_pkg::KIND_PUSH_FRONT
                                            : dqms_pkg::KIND_PUSH_BACK;
               else kind = at_front ? dqms_pkg::KIND_POP_FRONT : dqms_pkg::KIND_POP_BACK;
            end
            send_word(kind, pick_value(kind));
            sent++;
         end
      end
   endtask

   initial begin : main
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      test_empty_store();
      test_fill_to_full();
      test_search_hits();
      test_backpressure();
      test_random_traffic(RANDOM_ITEMS);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests: %0d stored, %0d removed, %0d searches with %0d hits",
               n_requests, n_stored, n_removed, n_searches, n_hits);
      $display("refused: %0d at full, %0d at empty; %0d unknown kinds; %0d responses checked",
               n_full_refused, n_empty_refused, n_unknown, checked_words);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches found", mismatch_count);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
src/dqms_pkg.sv
src/dqms_ram.sv
src/deque_with_membership_search.sv
src/dqms_checker.sv
dv/tb_top.sv
